@@ design/slpg_pkg.sv @@
// Package for the status LED pattern generator: word types, register codes,
// sequencer states and small color helpers. No dependencies.
package slpg_pkg;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  flight_state;
    logic        armed_flag;
    logic        storage_ok;
    logic        position_fix;
  } in_word_t;

  typedef struct packed {
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
  } out_word_t;

  typedef enum logic [2:0] {
    REG_BRIGHT = 3'd0,
    REG_MODE   = 3'd1,
    REG_RED    = 3'd2,
    REG_GREEN  = 3'd3,
    REG_BLUE   = 3'd4,
    REG_PERIOD = 3'd5,
    REG_BSTATE = 3'd6,
    REG_OVR    = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_SOLID   = 3'd1,
    MODE_BLINK   = 3'd2,
    MODE_BREATHE = 3'd3,
    MODE_RAINBOW = 3'd4,
    MODE_STROBE  = 3'd5,
    MODE_CYCLE   = 3'd6,
    MODE_STATE   = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVP,   // now / period  -> quotient and phase
    S_DIVT,   // tick / rate   -> tick remainder
    S_LVL,    // breathe level or rainbow position division
    S_SCL1,   // color * lvl / 255 (or *48/255)
    S_SCL2,   // color * brightness / 100
    S_DIV11,  // state cycle: quotient mod 11
    S_PICK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t hue_wheel(input logic [7:0] pin);
    logic [7:0] p;
    rgb_t c;
    p = 8'd255 - pin;
    if (p < 8'd85) begin
      c.r = 8'd255 - 8'(p * 3); c.g = 8'd0; c.b = 8'(p * 3);
    end else if (p < 8'd170) begin
      p = p - 8'd85;
      c.r = 8'd0; c.g = 8'(p * 3); c.b = 8'd255 - 8'(p * 3);
    end else begin
      p = p - 8'd170;
      c.r = 8'(p * 3); c.g = 8'd255 - 8'(p * 3); c.b = 8'd0;
    end
    return c;
  endfunction

endpackage

@@ design/status_led_pattern_generator.sv @@
// Status LED pattern generator: top level with registers and sequencer.
// Depends on slpg_pkg and slpg_divider.
//
// One poll word at a time. A poll that is muted or not yet due finishes with
// no result. A due poll runs a chain of bit-serial divisions on one shared
// 32-step divider: period phase and tick remainder always, then a level
// division for breathe or rainbow or a mod-11 step in state cycle, three
// divisions by 255 for the breathe level and the dim idle wheel, and three
// divisions by 100 for the brightness scaling when the color changed. The
// result sits in an output register, so a new poll is taken only once that
// word has been read. Configuration words are taken only while the
// sequencer is idle, and a pending configuration word holds off polls.
module status_led_pattern_generator #(
  parameter int PATTERN_RATE_HZ = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slpg_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slpg_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import slpg_pkg::*;

  localparam logic [31:0] STEP_MS = 32'(1000 / PATTERN_RATE_HZ);
  localparam logic [31:0] RATE    = 32'(PATTERN_RATE_HZ);

  // configuration registers
  logic [6:0]  bright_r;
  logic [2:0]  mode_r;
  logic [7:0]  bred_r, bgrn_r, bblu_r;
  logic [15:0] per_r;
  logic [3:0]  bst_r;
  logic [31:0] ovr_r;
  // block state
  logic [31:0] due_r, tick_r;
  rgb_t        last_r;
  logic        have_r, supp_r;

  state_t      st_r, st_nxt;
  in_word_t    item_r;
  logic [31:0] ph_r, quo_r, trem_r;
  logic [7:0]  lvl_r;
  rgb_t        col_r, scl_r;
  logic [1:0]  ch_r, ch_nxt;
  logic        out_valid_r;
  out_word_t   out_r;
  logic        scl_pend;   // first scaling division launched

  // divider
  logic        dv_start, dv_done;
  logic [31:0] dv_a, dv_b, dv_q, dv_rm;

  slpg_divider u_div (
    .clk, .rst_n, .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_rm)
  );

  logic cfg_fire, in_fire, out_fire;
  assign cfg_ready = (st_r == S_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (st_r == S_IDLE) && !out_valid_r && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // effective mode and muting for the held word
  logic        supp_eff;
  mode_t       mode_eff;
  logic [31:0] ovr_eff;
  logic        live;
  assign supp_eff = supp_r;
  assign mode_eff = supp_eff ? MODE_OFF : mode_t'(mode_r);
  assign ovr_eff  = supp_eff ? 32'd0 : ovr_r;
  logic [31:0] d_ovr, d_due;
  assign d_ovr = item_r.now_ms - ovr_eff;
  assign d_due = item_r.now_ms - due_r;
  assign live  = !d_ovr[31] && !d_due[31];

  logic [15:0] half;
  assign half = per_r >> 1;
  logic ph_lo;
  assign ph_lo = ph_r < {16'd0, half};

  // flight palette
  function automatic rgb_t flight_col(input logic [3:0] s, input logic armd,
                                      input logic fx, input rgb_t wheel48,
                                      input logic flash);
    rgb_t c;
    c = '0;
    case (s)
      4'd0: c = '{8'd16, 8'd16, 8'd16};
      4'd1: begin
        if (armd) c.r = 8'd64;
        else if (fx) c = wheel48;
        else c.g = 8'd16;
      end
      4'd2: c.r = 8'd64;
      4'd3, 4'd4: c = '{8'd48, 8'd0, 8'd48};
      4'd5, 4'd6: c = '{8'd0, 8'd40, 8'd40};
      4'd7, 4'd8: c = '{8'd48, 8'd32, 8'd0};
      4'd9: if (flash) c.g = 8'd255;
      default: if (flash) c.r = 8'd255;
    endcase
    return c;
  endfunction

  // color before level scaling; lvl_r/col_r path handled in sequence
  logic [31:0] tick_nx;
  assign tick_nx = tick_r;   // tick already advanced when sequence starts
  logic [7:0] tick5;
  assign tick5 = 8'(tick_nx * 5);
  logic flash, sdblk;
  assign flash = trem_r == 32'd1;
  assign sdblk = trem_r == 32'd0;

  // need wheel*48/255 scaling for idle-with-fix cases
  logic [3:0] fsel;
  always_comb begin
    case (mode_eff)
      MODE_CYCLE: fsel = quo_r[3:0];
      MODE_STATE: fsel = bst_r;
      default:    fsel = item_r.flight_state;
    endcase
  end
  logic farmed, ffix;
  assign farmed = (mode_eff == MODE_OFF) ? item_r.armed_flag : 1'b0;
  assign ffix   = (mode_eff == MODE_OFF) ? item_r.position_fix : 1'b1;
  logic use_flight, need_scl;
  assign use_flight = mode_eff == MODE_OFF || mode_eff == MODE_CYCLE ||
                      mode_eff == MODE_STATE;
  assign need_scl = (use_flight && fsel == 4'd1 && !farmed && ffix) ||
                    mode_eff == MODE_BREATHE;

  rgb_t base;   // color that feeds level scaling (or final when none)
  rgb_t bench;
  assign bench = '{bred_r, bgrn_r, bblu_r};
  always_comb begin
    base = '0;
    case (mode_eff)
      MODE_SOLID:   base = bench;
      MODE_BLINK:   if (ph_lo) base = bench;
      MODE_BREATHE: base = bench;
      MODE_RAINBOW: base = hue_wheel(lvl_r);
      MODE_STROBE:  if (ph_r < 32'd50) base = bench;
      default: begin
        if (use_flight && fsel == 4'd1 && !farmed && ffix) base = hue_wheel(tick5);
        else base = flight_col(fsel, farmed, ffix, scl_r, flash);
        if (mode_eff == MODE_OFF && !item_r.storage_ok && sdblk)
          base = '{8'd0, 8'd0, 8'd48};
      end
    endcase
  end
  // scl_r holds the scaled color once S_SCL1 is done
  rgb_t fin;
  assign fin = need_scl ?
               ((mode_eff == MODE_OFF && !item_r.storage_ok && sdblk) ?
                '{8'd0, 8'd0, 8'd48} : scl_r) : base;

  logic [7:0] base_ch;
  always_comb begin
    case (ch_r)
      2'd0:    base_ch = base.r;
      2'd1:    base_ch = base.g;
      default: base_ch = base.b;
    endcase
  end

  // sequencer
  logic        tick_inc, due_ld, emit, lvl_ld, scl_ld, scl2_ld, ph_ld;
  logic        trem_ld, quo_ld;
  logic [31:0] lvl_num;
  logic [15:0] phd;
  assign phd = ph_lo ? ph_r[15:0] : (per_r - ph_r[15:0]);
  assign lvl_num = (mode_eff == MODE_BREATHE) ? 32'(phd) * 32'd255 : ph_r * 32'd255;

  always_comb begin
    st_nxt = st_r; ch_nxt = ch_r;
    dv_start = 1'b0; dv_a = '0; dv_b = 32'd1;
    tick_inc = 1'b0; due_ld = 1'b0; emit = 1'b0;
    lvl_ld = 1'b0; scl_ld = 1'b0; scl2_ld = 1'b0; ph_ld = 1'b0;
    trem_ld = 1'b0; quo_ld = 1'b0;
    case (st_r)
      S_IDLE: if (in_fire) st_nxt = S_PICK;
      S_PICK: begin
        // PICK used first as gate: decide due
        if (!live) begin
          st_nxt = S_IDLE;
        end else begin
          tick_inc = 1'b1; due_ld = 1'b1;
          dv_start = 1'b1; dv_a = item_r.now_ms; dv_b = {16'd0, per_r};
          st_nxt = S_DIVP;
        end
      end
      S_DIVP: if (dv_done) begin
        ph_ld = 1'b1; quo_ld = 1'b1;
        dv_start = 1'b1; dv_a = tick_r; dv_b = RATE;
        st_nxt = S_DIVT;
      end
      S_DIVT: if (dv_done) begin
        trem_ld = 1'b1;
        if (mode_eff == MODE_CYCLE) begin
          dv_start = 1'b1; dv_a = quo_r; dv_b = 32'd11; st_nxt = S_DIV11;
        end else if (mode_eff == MODE_BREATHE || mode_eff == MODE_RAINBOW) begin
          dv_start = 1'b1; dv_a = lvl_num;
          dv_b = (mode_eff == MODE_BREATHE) ? {16'd0, half} : {16'd0, per_r};
          st_nxt = S_LVL;
        end else begin
          st_nxt = S_SCL1; ch_nxt = 2'd0;
        end
      end
      S_DIV11: if (dv_done) begin
        quo_ld = 1'b1; st_nxt = S_SCL1; ch_nxt = 2'd0;
      end
      S_LVL: if (dv_done) begin
        lvl_ld = 1'b1; st_nxt = S_SCL1; ch_nxt = 2'd0;
      end
      S_SCL1: begin
        if (!need_scl) begin
          st_nxt = S_OUT;
        end else if (!dv_done && ch_r == 2'd0 && !scl_pend) begin
          dv_start = 1'b1;
          dv_a = 32'(base_ch) * ((mode_eff == MODE_BREATHE) ? 32'(lvl_r) : 32'd48);
          dv_b = 32'd255;
        end else if (dv_done) begin
          scl_ld = 1'b1;
          if (ch_r == 2'd2) begin
            st_nxt = S_OUT; ch_nxt = 2'd0;
          end else begin
            ch_nxt = ch_r + 2'd1;
            dv_start = 1'b1;
            dv_b = 32'd255;
            dv_a = 32'(ch_r == 2'd0 ? base.g : base.b) *
                   ((mode_eff == MODE_BREATHE) ? 32'(lvl_r) : 32'd48);
          end
        end
      end
      S_OUT: begin
        if (have_r && fin == last_r) begin
          st_nxt = S_IDLE;
        end else begin
          dv_start = 1'b1; dv_a = 32'(fin.r) * 32'(bright_r); dv_b = 32'd100;
          ch_nxt = 2'd0; st_nxt = S_SCL2;
        end
      end
      S_SCL2: if (dv_done) begin
        scl2_ld = 1'b1;
        if (ch_r == 2'd2) begin
          emit = 1'b1; st_nxt = S_IDLE;
        end else begin
          ch_nxt = ch_r + 2'd1; dv_start = 1'b1; dv_b = 32'd100;
          dv_a = 32'(ch_r == 2'd0 ? fin.g : fin.b) * 32'(bright_r);
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) scl_pend <= 1'b0;
    else if (st_r != S_SCL1) scl_pend <= 1'b0;
    else if (dv_start) scl_pend <= 1'b1;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ch_r <= 2'd0; out_valid_r <= 1'b0;
      bright_r <= 7'd100; mode_r <= 3'd0; bred_r <= '0; bgrn_r <= '0;
      bblu_r <= '0; per_r <= 16'd1000; bst_r <= '0; ovr_r <= '0;
      due_r <= '0; tick_r <= '0; last_r <= '0; have_r <= 1'b0; supp_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ch_r <= ch_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
      if (in_fire && in_data.armed_flag) supp_r <= 1'b1;
      if (tick_inc) tick_r <= tick_r + 32'd1;
      if (due_ld) due_r <= item_r.now_ms + STEP_MS;
      if (emit) begin
        last_r <= fin; have_r <= 1'b1;
      end
      if (cfg_fire) begin
        case (cfg_index)
          4'(REG_BRIGHT): begin
            bright_r <= (cfg_data[6:0] > 7'd100) ? 7'd100 : cfg_data[6:0];
            have_r <= 1'b0;
          end
          4'(REG_MODE):   begin mode_r <= cfg_data[2:0]; supp_r <= 1'b0; end
          4'(REG_RED):    begin bred_r <= cfg_data[7:0]; supp_r <= 1'b0; end
          4'(REG_GREEN):  begin bgrn_r <= cfg_data[7:0]; supp_r <= 1'b0; end
          4'(REG_BLUE):   begin bblu_r <= cfg_data[7:0]; supp_r <= 1'b0; end
          4'(REG_PERIOD): begin
            per_r <= (cfg_data[15:0] < 16'd50) ? 16'd50 : cfg_data[15:0];
            supp_r <= 1'b0;
          end
          4'(REG_BSTATE): begin bst_r <= cfg_data[3:0]; supp_r <= 1'b0; end
          4'(REG_OVR):    begin ovr_r <= cfg_data; supp_r <= 1'b0; end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
    if (ph_ld) ph_r <= dv_rm;
    // state cycle keeps (now / period) mod 11 from the mod-11 division
    if (quo_ld) quo_r <= (st_r == S_DIV11) ? dv_rm : dv_q;
    if (trem_ld) trem_r <= dv_rm;
    if (lvl_ld) lvl_r <= (dv_q > 32'd255) ? 8'd255 : dv_q[7:0];
    if (scl_ld) begin
      case (ch_r)
        2'd0:    scl_r.r <= dv_q[7:0];
        2'd1:    scl_r.g <= dv_q[7:0];
        default: scl_r.b <= dv_q[7:0];
      endcase
    end
    if (scl2_ld) begin
      case (ch_r)
        2'd0:    out_r.led_red   <= dv_q[7:0];
        2'd1:    out_r.led_green <= dv_q[7:0];
        default: out_r.led_blue  <= dv_q[7:0];
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready) else $error("poll taken while busy");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid) else $error("result lost");
  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    bright_r <= 7'd100) else $error("brightness out of range");
`endif
endmodule

@@ design/slpg_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Does not use slpg_pkg; no dependencies.
module slpg_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] q_r, q_nxt, rem_r, rem_nxt, dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[31]} - {1'b0, dvs_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
endmodule
